>>> src/mbs_pkg.sv
// shared constants and types for the mesh bounding sphere block
// no dependencies; used by mesh_bounding_sphere_top, mbs_checker and the testbench top
package mbs_pkg;

    // field and register widths
    localparam int FIELD_W       = 32;
    localparam int OFFSET_W      = 4;
    localparam int STRIDE_W      = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    // parameter defaults
    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAX_STRIDE_DEF  = 16;

    // stride limits and reset values
    localparam int STRIDE_MIN    = 3;
    localparam int STRIDE_RESET  = 3;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POSITION_OFFSET = 2'd0,
        REG_VERTEX_STRIDE   = 2'd1
    } t_reg_index;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SQUARE = 4'b0010,
        S_ROOT   = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

endpackage

>>> src/mesh_bounding_sphere_top.sv
// bounding sphere of a mesh's vertex positions, one buffer word per beat; uses mbs_pkg
// throughput: one word per cycle while o_in_stall is low; the last word starts squaring on one
// shared multiplier, then a bit-serial square root
// o_out_valid rises when the square root ends, or in the cycle after the last word is taken
// when the mesh held no valid position
// input stalls from the last word until the result beat is taken; reset: sync active low
module mesh_bounding_sphere_top #(
    parameter int COORD_WIDTH = mbs_pkg::COORD_WIDTH_DEF,
    parameter int MAX_STRIDE  = mbs_pkg::MAX_STRIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // word input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [mbs_pkg::FIELD_W-1:0] i_word,
    input  logic                               i_last,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [mbs_pkg::FIELD_W-1:0] o_center_x,
    output logic signed [mbs_pkg::FIELD_W-1:0] o_center_y,
    output logic signed [mbs_pkg::FIELD_W-1:0] o_center_z,
    output logic [mbs_pkg::FIELD_W-1:0]        o_radius,
    output logic                               o_no_vertices
);

    localparam int CW = COORD_WIDTH;
    localparam int FW = mbs_pkg::FIELD_W;
    localparam int PW = (MAX_STRIDE > 16) ? $clog2(MAX_STRIDE) : 4;
    localparam int SW = PW + 1;
    localparam int QW = CW + 1;
    localparam int RW = 2 * QW;
    localparam int IW = $clog2(QW);

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

    // registers
    mbs_pkg::t_state              r_state, n_state;
    logic [mbs_pkg::OFFSET_W-1:0] r_pos_offset, n_pos_offset;
    logic [mbs_pkg::STRIDE_W-1:0] r_stride, n_stride;
    logic [PW-1:0]                r_phase, n_phase;
    logic                         r_seen, n_seen;
    logic signed [CW-1:0]         r_held_x, n_held_x;
    logic signed [CW-1:0]         r_held_y, n_held_y;
    logic signed [CW-1:0]         r_low [3];
    logic signed [CW-1:0]         n_low [3];
    logic signed [CW-1:0]         r_high [3];
    logic signed [CW-1:0]         n_high [3];
    logic                         r_any_valid, n_any_valid;
    logic [1:0]                   r_axis, n_axis;
    logic [IW-1:0]                r_iter, n_iter;
    logic [2*CW-1:0]              r_prod, n_prod;
    logic [RW-1:0]                r_acc, n_acc;
    logic [QW+1:0]                r_rem, n_rem;
    logic [QW-1:0]                r_root, n_root;
    logic signed [FW-1:0]         r_center [3];
    logic signed [FW-1:0]         n_center [3];
    logic [FW-1:0]                r_radius, n_radius;
    logic                         r_no_vertices, n_no_vertices;

    // datapath helpers
    logic                         in_fire;
    logic                         out_fire;
    logic signed [CW-1:0]         word_c;
    logic [SW-1:0]                stride_raw;
    logic [SW-1:0]                stride_eff;
    logic [SW-1:0]                phase_inc;
    logic                         take_vertex;
    logic                         vertex_ok;
    logic signed [CW-1:0]         vtx [3];
    logic signed [CW-1:0]         acc_low [3];
    logic signed [CW-1:0]         acc_high [3];
    logic signed [CW:0]           diff_c;
    logic [CW-1:0]                dist_c;
    logic [2*CW-1:0]              square_c;
    logic signed [CW:0]           mid_sum [3];
    logic signed [CW:0]           mid_half [3];
    logic [QW+1:0]                rem_sh;
    logic [QW+1:0]                trial;
    logic                         root_ge;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != mbs_pkg::S_IDLE);
    assign o_out_valid = (r_state == mbs_pkg::S_OUT);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_fire    = o_out_valid && !i_out_stall;

    // result fields
    assign o_center_x    = r_center[0];
    assign o_center_y    = r_center[1];
    assign o_center_z    = r_center[2];
    assign o_radius      = r_radius;
    assign o_no_vertices = r_no_vertices;

    // incoming coordinate and saturated stride
    assign word_c     = signed'(i_word[CW-1:0]);
    assign stride_raw = SW'(r_stride);
    always_comb begin
        if (stride_raw < SW'(mbs_pkg::STRIDE_MIN)) begin
            stride_eff = SW'(mbs_pkg::STRIDE_MIN);
        end else if (stride_raw > SW'(MAX_STRIDE)) begin
            stride_eff = SW'(MAX_STRIDE);
        end else begin
            stride_eff = stride_raw;
        end
    end
    assign phase_inc = SW'(r_phase) + SW'(1);

    // vertex check and box update for a z word
    assign take_vertex = r_seen && (r_phase == PW'(2));
    assign vtx[0]      = r_held_x;
    assign vtx[1]      = r_held_y;
    assign vtx[2]      = word_c;
    assign vertex_ok   = take_vertex && (r_held_x != C_MIN) && (r_held_y != C_MIN)
                         && (word_c != C_MIN);
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc_low[a]  = (vertex_ok && (vtx[a] < r_low[a]))  ? vtx[a] : r_low[a];
            acc_high[a] = (vertex_ok && (vtx[a] > r_high[a])) ? vtx[a] : r_high[a];
        end
    end

    // shared multiplier input: extent of the selected axis
    always_comb begin
        unique case (r_axis)
            2'd0:    diff_c = {r_high[0][CW-1], r_high[0]} - {r_low[0][CW-1], r_low[0]};
            2'd1:    diff_c = {r_high[1][CW-1], r_high[1]} - {r_low[1][CW-1], r_low[1]};
            2'd2:    diff_c = {r_high[2][CW-1], r_high[2]} - {r_low[2][CW-1], r_low[2]};
            default: diff_c = '0;
        endcase
    end
    assign dist_c   = diff_c[CW-1:0];
    assign square_c = {{CW{1'b0}}, dist_c} * {{CW{1'b0}}, dist_c};

    // floored midpoints
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mid_sum[a]  = {r_low[a][CW-1], r_low[a]} + {r_high[a][CW-1], r_high[a]};
            mid_half[a] = mid_sum[a] >>> 1;
        end
    end

    // one restoring square root step, two radicand bits per cycle
    assign rem_sh  = {r_rem[QW-1:0], r_acc[RW-1:RW-2]};
    assign trial   = {r_root, 2'b01};
    assign root_ge = (rem_sh >= trial);

    // sequencer and next state
    always_comb begin
        n_state       = r_state;
        n_pos_offset  = r_pos_offset;
        n_stride      = r_stride;
        n_phase       = r_phase;
        n_seen        = r_seen;
        n_held_x      = r_held_x;
        n_held_y      = r_held_y;
        n_low         = r_low;
        n_high        = r_high;
        n_any_valid   = r_any_valid;
        n_axis        = r_axis;
        n_iter        = r_iter;
        n_prod        = r_prod;
        n_acc         = r_acc;
        n_rem         = r_rem;
        n_root        = r_root;
        n_center      = r_center;
        n_radius      = r_radius;
        n_no_vertices = r_no_vertices;

        // register writes
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mbs_pkg::REG_POSITION_OFFSET:
                    n_pos_offset = i_cfg_data[mbs_pkg::OFFSET_W-1:0];
                mbs_pkg::REG_VERTEX_STRIDE:
                    n_stride = i_cfg_data[mbs_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            mbs_pkg::S_IDLE: begin
                if (in_fire) begin
                    // word phase tracking
                    if (!r_seen) begin
                        if (r_phase >= PW'(r_pos_offset)) begin
                            n_held_x = word_c;
                            n_seen   = 1'b1;
                            n_phase  = PW'(1);
                        end else begin
                            n_phase = r_phase + PW'(1);
                        end
                    end else begin
                        if (r_phase == PW'(0)) begin
                            n_held_x = word_c;
                        end else if (r_phase == PW'(1)) begin
                            n_held_y = word_c;
                        end
                        n_phase = (phase_inc >= stride_eff) ? '0 : phase_inc[PW-1:0];
                    end
                    n_low       = acc_low;
                    n_high      = acc_high;
                    n_any_valid = r_any_valid || vertex_ok;

                    // end of buffer: start the result
                    if (i_last) begin
                        n_phase     = '0;
                        n_seen      = 1'b0;
                        n_held_x    = '0;
                        n_held_y    = '0;
                        n_any_valid = 1'b0;
                        n_axis      = '0;
                        n_prod      = '0;
                        n_acc       = '0;
                        if (r_any_valid || vertex_ok) begin
                            n_no_vertices = 1'b0;
                            n_state       = mbs_pkg::S_SQUARE;
                        end else begin
                            n_no_vertices = 1'b1;
                            n_center[0]   = '0;
                            n_center[1]   = '0;
                            n_center[2]   = '0;
                            n_radius      = '0;
                            n_state       = mbs_pkg::S_OUT;
                        end
                    end
                end
            end
            mbs_pkg::S_SQUARE: begin
                // square one axis, add the previous square
                n_prod = square_c;
                n_acc  = r_acc + RW'(r_prod);
                n_axis = r_axis + 2'd1;
                if (r_axis == 2'd0) begin
                    for (int a = 0; a < 3; a++) begin
                        n_center[a] = FW'(signed'(mid_half[a][CW-1:0]));
                    end
                end
                if (r_axis == 2'd3) begin
                    for (int a = 0; a < 3; a++) begin
                        n_low[a]  = C_MAX;
                        n_high[a] = C_MIN;
                    end
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = '0;
                    n_state = mbs_pkg::S_ROOT;
                end
            end
            mbs_pkg::S_ROOT: begin
                n_rem  = root_ge ? (rem_sh - trial) : rem_sh;
                n_root = {r_root[QW-2:0], root_ge};
                n_acc  = {r_acc[RW-3:0], 2'b00};
                n_iter = r_iter + IW'(1);
                if (r_iter == IW'(QW - 1)) begin
                    n_radius = FW'(n_root[QW-1:1]);
                    n_state  = mbs_pkg::S_OUT;
                end
            end
            mbs_pkg::S_OUT: begin
                if (out_fire) begin
                    n_state = mbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mbs_pkg::S_IDLE;
            end
        endcase
    end

    // control and box state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mbs_pkg::S_IDLE;
            r_pos_offset <= '0;
            r_stride     <= mbs_pkg::STRIDE_W'(mbs_pkg::STRIDE_RESET);
            r_phase      <= '0;
            r_seen       <= 1'b0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_any_valid  <= 1'b0;
            r_axis       <= '0;
            r_iter       <= '0;
            for (int a = 0; a < 3; a++) begin
                r_low[a]  <= C_MAX;
                r_high[a] <= C_MIN;
            end
        end else begin
            r_state      <= n_state;
            r_pos_offset <= n_pos_offset;
            r_stride     <= n_stride;
            r_phase      <= n_phase;
            r_seen       <= n_seen;
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
            r_any_valid  <= n_any_valid;
            r_axis       <= n_axis;
            r_iter       <= n_iter;
            r_low        <= n_low;
            r_high       <= n_high;
        end
    end

    // arithmetic and result registers
    always_ff @(posedge i_clk) begin
        r_prod        <= n_prod;
        r_acc         <= n_acc;
        r_rem         <= n_rem;
        r_root        <= n_root;
        r_center      <= n_center;
        r_radius      <= n_radius;
        r_no_vertices <= n_no_vertices;
    end

    // checks
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_last |=> o_in_stall)
        else $error("input taken right after last word");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_vertices |-> (o_radius == '0) && (o_center_x == '0)
        && (o_center_y == '0) && (o_center_z == '0))
        else $error("empty mesh result carries nonzero fields");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_valid |-> (r_low[0] <= r_high[0]) && (r_low[1] <= r_high[1])
        && (r_low[2] <= r_high[2]))
        else $error("box corners out of order");

    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mbs_pkg::S_ROOT |-> r_iter <= IW'(QW - 1))
        else $error("square root step count overrun");

endmodule

>>> sim/mbs_checker.sv
// scoreboard for the mesh bounding sphere block: mirrors the box and sphere arithmetic
// watches the register, word and result channels; depends on mbs_pkg
module mbs_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // register write channel
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [mbs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // word channel
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [mbs_pkg::FIELD_W-1:0]   i_word,
    input  logic                                 i_last,
    // result channel
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [mbs_pkg::FIELD_W-1:0]   i_center_x,
    input  logic signed [mbs_pkg::FIELD_W-1:0]   i_center_y,
    input  logic signed [mbs_pkg::FIELD_W-1:0]   i_center_z,
    input  logic [mbs_pkg::FIELD_W-1:0]          i_radius,
    input  logic                                 i_no_vertices,
    // status for the testbench top
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_spheres,
    output int                                   o_empty_spheres
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W  = mbs_pkg::FIELD_W;
    localparam int OFFSET_W = mbs_pkg::OFFSET_W;
    localparam int STRIDE_W = mbs_pkg::STRIDE_W;

    typedef struct packed {
        logic signed [FIELD_W-1:0] center_x;
        logic signed [FIELD_W-1:0] center_y;
        logic signed [FIELD_W-1:0] center_z;
        logic [FIELD_W-1:0]        radius;
        logic                      no_vertices;
    } t_sphere;

    localparam logic signed [FIELD_W-1:0] NEG_INF = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic signed [FIELD_W-1:0] POS_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

    // register copies
    logic [OFFSET_W-1:0] offset_reg;
    logic [STRIDE_W-1:0] stride_reg;

    // per-mesh state
    int                        phase;
    bit                        seen_offset;
    bit                        any_valid;
    logic signed [FIELD_W-1:0] held_x;
    logic signed [FIELD_W-1:0] held_y;
    logic signed [FIELD_W-1:0] box_lo [3];
    logic signed [FIELD_W-1:0] box_hi [3];

    t_sphere expected_spheres[$];
    int      fail_count;
    int      spheres;
    int      empty_spheres;

    task automatic report(input string what);
        $display("%t mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic clear_mesh();
        int a;
        phase = 0;
        seen_offset = 1'b0;
        any_valid = 1'b0;
        held_x = '0;
        held_y = '0;
        for (a = 0; a < 3; a++) begin
            box_lo[a] = POS_MAX;
            box_hi[a] = NEG_INF;
        end
    endtask

    // floor of the midpoint, one extra bit keeps the sum exact
    function automatic logic signed [FIELD_W-1:0] floor_mid(
        input logic signed [FIELD_W-1:0] a,
        input logic signed [FIELD_W-1:0] b
    );
        logic [FIELD_W:0] sum;
        sum = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
        return sum[FIELD_W:1];
    endfunction

    // half the truncated root of the squared box diagonal
    function automatic logic [FIELD_W-1:0] sphere_radius();
        logic [FIELD_W:0]     diff;
        logic [2*FIELD_W+1:0] span;
        logic [2*FIELD_W+1:0] diag_sq;
        logic [FIELD_W+1:0]   root;
        logic [FIELD_W+1:0]   trial;
        logic [2*FIELD_W+3:0] trial_sq;
        int a;
        int b;
        diag_sq = '0;
        for (a = 0; a < 3; a++) begin
            diff = {box_hi[a][FIELD_W-1], box_hi[a]} - {box_lo[a][FIELD_W-1], box_lo[a]};
            span = diff;
            diag_sq = diag_sq + span * span;
        end
        // bit-serial root, one result bit per step from the top
        root = '0;
        for (b = FIELD_W; b >= 0; b--) begin
            trial = root;
            trial[b] = 1'b1;
            trial_sq = trial * trial;
            if (trial_sq <= {2'b00, diag_sq})
                root = trial;
        end
        return root[FIELD_W:1];
    endfunction

    task automatic add_vertex(input logic signed [FIELD_W-1:0] z);
        logic signed [FIELD_W-1:0] v [3];
        int a;
        v[0] = held_x;
        v[1] = held_y;
        v[2] = z;
        // minus infinity on any axis drops the whole position
        if (v[0] == NEG_INF || v[1] == NEG_INF || v[2] == NEG_INF)
            return;
        for (a = 0; a < 3; a++) begin
            if (v[a] < box_lo[a]) box_lo[a] = v[a];
            if (v[a] > box_hi[a]) box_hi[a] = v[a];
        end
        any_valid = 1'b1;
    endtask

    // advance the word position and predict the sphere on the last word
    task automatic fold_word(input logic signed [FIELD_W-1:0] w, input logic last);
        int      stride_eff;
        t_sphere s;
        stride_eff = stride_reg;
        if (stride_eff < mbs_pkg::STRIDE_MIN) stride_eff = mbs_pkg::STRIDE_MIN;
        if (stride_eff > mbs_pkg::MAX_STRIDE_DEF) stride_eff = mbs_pkg::MAX_STRIDE_DEF;

        if (!seen_offset) begin
            if (phase >= offset_reg) begin
                held_x = w;
                seen_offset = 1'b1;
                phase = 1;
            end else begin
                phase++;
            end
        end else begin
            if (phase == 0) held_x = w;
            else if (phase == 1) held_y = w;
            else if (phase == 2) add_vertex(w);
            phase = (phase + 1 >= stride_eff) ? 0 : phase + 1;
        end

        if (last) begin
            s = '0;
            if (!any_valid) begin
                s.no_vertices = 1'b1;
            end else begin
                s.center_x = floor_mid(box_lo[0], box_hi[0]);
                s.center_y = floor_mid(box_lo[1], box_hi[1]);
                s.center_z = floor_mid(box_lo[2], box_hi[2]);
                s.radius = sphere_radius();
            end
            expected_spheres.push_back(s);
            clear_mesh();
        end
    endtask

    task automatic check_sphere();
        t_sphere want;
        if (expected_spheres.size() == 0) begin
            report("result beat with no sphere pending");
            return;
        end
        want = expected_spheres.pop_front();
        spheres++;
        if (want.no_vertices) empty_spheres++;
        if (i_no_vertices !== want.no_vertices)
            report($sformatf("no_vertices got %b want %b", i_no_vertices, want.no_vertices));
        if (i_center_x !== want.center_x)
            report($sformatf("center_x got %h want %h", i_center_x, want.center_x));
        if (i_center_y !== want.center_y)
            report($sformatf("center_y got %h want %h", i_center_y, want.center_y));
        if (i_center_z !== want.center_z)
            report($sformatf("center_z got %h want %h", i_center_z, want.center_z));
        if (i_radius !== want.radius)
            report($sformatf("radius got %h want %h", i_radius, want.radius));
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offset_reg = '0;
            stride_reg = mbs_pkg::STRIDE_RESET;
            clear_mesh();
            expected_spheres.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_sphere();
            // a word beat sees the registers as they were before this edge
            if (i_in_valid && !i_in_stall)
                fold_word(i_word, i_last);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mbs_pkg::REG_POSITION_OFFSET: offset_reg = i_cfg_data[OFFSET_W-1:0];
                    mbs_pkg::REG_VERTEX_STRIDE:   stride_reg = i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= expected_spheres.size();
        o_spheres       <= spheres;
        o_empty_spheres <= empty_spheres;
    end

endmodule

>>> sim/tb_mesh_bounding_sphere_top.sv
// testbench top for mesh_bounding_sphere_top: clock, reset, register setup and vertex buffers
// depends on mbs_pkg, mesh_bounding_sphere_top and mbs_checker
module tb_mesh_bounding_sphere_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W     = mbs_pkg::FIELD_W;
    localparam int CFG_INDEX_W = mbs_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = mbs_pkg::CFG_DATA_W;
    localparam int OFFSET_W    = mbs_pkg::OFFSET_W;
    localparam int STRIDE_W    = mbs_pkg::STRIDE_W;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_UNIT,
        SPREAD_EXTREME,
        SPREAD_MID
    } t_spread;

    localparam int WORD_TARGET    = 1800;
    localparam int QUIET_FROM     = 1500;
    localparam int WORDS_PER_SET  = 200;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_BURST      = 16;

    localparam logic [FIELD_W-1:0] NEG_INF  = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] NEG_MAX  = {1'b1, {(FIELD_W-2){1'b0}}, 1'b1};
    localparam logic [FIELD_W-1:0] POS_MAX  = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic [FIELD_W-1:0] MINUS_1  = {FIELD_W{1'b1}};

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic signed [FIELD_W-1:0]   in_word   = '0;
    logic                        in_last   = 1'b0;
    logic                        out_stall = 1'b0;
    logic                        cfg_ready;
    logic                        in_stall;
    logic                        out_valid;
    logic signed [FIELD_W-1:0]   center_x;
    logic signed [FIELD_W-1:0]   center_y;
    logic signed [FIELD_W-1:0]   center_z;
    logic [FIELD_W-1:0]          radius;
    logic                        no_vertices;

    int fail_count;
    int pending;
    int spheres;
    int empty_spheres;

    int in_gap_odds    = 0;
    int out_stall_odds = 0;
    int cur_offset     = 0;
    int cur_stride     = mbs_pkg::STRIDE_RESET;
    int word_count     = 0;
    int stuck_cycles   = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    mesh_bounding_sphere_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_word        (in_word),
        .i_last        (in_last),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_center_x    (center_x),
        .o_center_y    (center_y),
        .o_center_z    (center_z),
        .o_radius      (radius),
        .o_no_vertices (no_vertices)
    );

    mbs_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_word          (in_word),
        .i_last          (in_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_center_x      (center_x),
        .i_center_y      (center_y),
        .i_center_z      (center_z),
        .i_radius        (radius),
        .i_no_vertices   (no_vertices),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_spheres       (spheres),
        .o_empty_spheres (empty_spheres)
    );

    // receiver back-pressure in random bursts
    initial begin
        forever begin
            @(posedge clk);
            if (out_stall_odds != 0 && $urandom_range(99) < out_stall_odds) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // end the run when no channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (cfg_valid && cfg_ready)
                || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", stuck_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic int pick_odds();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] coord_value(input t_spread spread);
        logic [FIELD_W-1:0] v;
        if ($urandom_range(24) == 0)
            return NEG_INF;
        case (spread)
            SPREAD_UNIT: v = $urandom_range(32'h0002_0000) - 32'h0001_0000;
            SPREAD_EXTREME: begin
                case ($urandom_range(4))
                    0:       v = POS_MAX;
                    1:       v = NEG_MAX;
                    2:       v = '0;
                    3:       v = MINUS_1;
                    default: v = 1;
                endcase
            end
            SPREAD_MID: begin
                v = $urandom();
                v[FIELD_W-1:24] = {(FIELD_W-24){v[23]}};
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // one word beat, with an optional gap in front of it
    task automatic send_word(input logic [FIELD_W-1:0] w, input logic last);
        if (in_gap_odds != 0 && $urandom_range(99) < in_gap_odds) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        in_last  <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_buffer(input logic [FIELD_W-1:0] words[$]);
        int k;
        for (k = 0; k < words.size(); k++)
            send_word(words[k], k == words.size() - 1);
        word_count += words.size();
    endtask

    // vertex buffer shaped by the current layout: mostly whole records
    task automatic send_random_mesh();
        int      nverts;
        int      len;
        int      shape;
        int      k;
        t_spread spread;
        shape  = $urandom_range(99);
        nverts = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        if (shape < 75)
            len = cur_offset + (nverts - 1) * cur_stride + 3 + $urandom_range(cur_stride - 3);
        else if (shape < 87)
            len = cur_offset + nverts * cur_stride + $urandom_range(1, 2);
        else
            len = $urandom_range(1, cur_offset + 2 * cur_stride + 3);
        spread = t_spread'($urandom_range(3));
        for (k = 0; k < len; k++) begin
            send_word(coord_value(spread), k == len - 1);
            word_count++;
        end
    endtask

    // stop sending and let the last sphere come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_layout(input int offset, input int stride_code, input bit spare_write);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom();
        data[OFFSET_W-1:0] = offset[OFFSET_W-1:0];
        write_reg(mbs_pkg::REG_POSITION_OFFSET, data);
        data = $urandom();
        data[STRIDE_W-1:0] = stride_code[STRIDE_W-1:0];
        write_reg(mbs_pkg::REG_VERTEX_STRIDE, data);
        if (spare_write)
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
        cfg_valid <= 1'b0;
        cur_offset = offset;
        cur_stride = stride_code < mbs_pkg::STRIDE_MIN ? mbs_pkg::STRIDE_MIN :
                     stride_code > mbs_pkg::MAX_STRIDE_DEF ? mbs_pkg::MAX_STRIDE_DEF :
                     stride_code;
    endtask

    initial begin
        int set_no;
        int set_start;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed buffers on the reset layout: offset 0, stride 3
        in_gap_odds    = 20;
        out_stall_odds = 20;
        send_buffer('{NEG_MAX});
        send_buffer('{POS_MAX, NEG_MAX, 32'h0, NEG_MAX, POS_MAX, MINUS_1});
        send_buffer('{NEG_INF, 32'h5, 32'h5});
        send_buffer('{32'h1, NEG_INF, 32'h2, 32'h3, 32'h4, NEG_INF, 32'h7, 32'h8, 32'h9});
        send_buffer('{32'h1, 32'h2, 32'h3, 32'h4, 32'h5});
        drain();

        // random buffers under a series of layouts, extremes first
        set_no = 0;
        while (word_count < WORD_TARGET) begin
            case (set_no)
                0:       set_layout(15, mbs_pkg::MAX_STRIDE_DEF, 1'b0);
                1:       set_layout(0, mbs_pkg::STRIDE_MIN, 1'b1);
                2:       set_layout(2, 0, 1'b0);
                3:       set_layout(9, 31, 1'b1);
                default: set_layout($urandom_range(15), $urandom_range(31),
                                    $urandom_range(3) == 0);
            endcase
            if (word_count >= QUIET_FROM) begin
                in_gap_odds    = 0;
                out_stall_odds = 0;
            end else begin
                in_gap_odds    = pick_odds();
                out_stall_odds = pick_odds();
            end
            set_start = word_count;
            while (word_count - set_start < WORDS_PER_SET && word_count < WORD_TARGET) begin
                // the closing stretch runs with no idling at all
                if (word_count >= QUIET_FROM) begin
                    in_gap_odds    = 0;
                    out_stall_odds = 0;
                end
                send_random_mesh();
            end
            drain();
            set_no++;
        end

        $display("summary: %0d buffer words under %0d layouts", word_count, set_no + 1);
        $display("summary: %0d spheres checked, %0d of them empty", spheres, empty_spheres);
        if (pending != 0)
            $display("%0d expected spheres never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> mesh_bounding_sphere_top.f
src/mbs_pkg.sv
src/mesh_bounding_sphere_top.sv
sim/mbs_checker.sv
sim/tb_mesh_bounding_sphere_top.sv
